// ----- hdl/mpsf_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI port-select framer package
// Shared types, mode codes and byte constants for the framer.
// ----------------------------------------------------------------------------
package mpsf_pkg;

	// Default number of output ports and depth of the job queue.
	localparam int NUM_PORTS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Adaptor mode codes.
	localparam logic [2:0] MODE_SOUND_MODULE    = 3'd0;
	localparam logic [2:0] MODE_SINGLE_PORT     = 3'd1;
	localparam logic [2:0] MODE_SINGLE_ADDRESSED = 3'd2;
	localparam logic [2:0] MODE_MULTI_BURST     = 3'd3;
	localparam logic [2:0] MODE_GENERIC         = 3'd4;

	// Configuration register indexes.
	localparam logic REG_ADAPTOR_MODE = 1'b0;
	localparam logic REG_IDLE_TIMEOUT = 1'b1;

	// Input opcodes.
	localparam logic OP_MIDI_BYTE = 1'b0;
	localparam logic OP_IDLE_TICK = 1'b1;

	// Byte constants of the framing scheme.
	localparam logic [7:0] BYTE_PORT_SELECT = 8'hF5;
	localparam logic [3:0] ADDR_LOW_NIBBLE  = 4'h8;
	localparam logic [7:0] ADDR_PORT_ZERO   = 8'h08;
	localparam logic [7:0] ADDR_PORT_ZERO_SUB = 8'hF8;
	localparam logic [7:0] STATUS_LOW       = 8'h80;
	localparam logic [7:0] STATUS_SYSTEM    = 8'hF0;

	// Reset values of the configuration registers.
	localparam logic [2:0]  ADAPTOR_MODE_RST = MODE_GENERIC;
	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd3000;

	typedef struct packed {
		logic [2:0]  adaptor_mode;
		logic [15:0] idle_timeout;
	} cfg_t;

	// One job: up to four bytes to send and the index of the final one.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} job_t;

endpackage

// ----- hdl/mpsf_in_if.sv -----
// ----------------------------------------------------------------------------
// MIDI item channel
// Valid/ready channel carrying tagged MIDI bytes and idle ticks.
// ----------------------------------------------------------------------------
interface mpsf_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [3:0] port;
	logic [7:0] data_byte;
	logic       burst_start;

	modport source (output valid, output opcode, output port, output data_byte,
		output burst_start, input ready);
	modport sink (input valid, input opcode, input port, input data_byte,
		input burst_start, output ready);
endinterface

// ----- hdl/mpsf_out_if.sv -----
// ----------------------------------------------------------------------------
// Serial byte channel
// Valid/ready channel carrying framed bytes towards the transmitter.
// ----------------------------------------------------------------------------
interface mpsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;

	modport source (output valid, output tx_byte, output last, input ready);
	modport sink (input valid, input tx_byte, input last, output ready);
endinterface

// ----- hdl/mpsf_front.sv -----
// ----------------------------------------------------------------------------
// Framer front end
// Accepts words, keeps the port-select state and builds byte jobs.
// ----------------------------------------------------------------------------
module mpsf_front #(
	parameter int NUM_PORTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  mpsf_pkg::cfg_t cfg,
	mpsf_in_if.sink      midi,
	output logic         push_valid,
	output mpsf_pkg::job_t push_job,
	input  logic         push_ready
);
	import mpsf_pkg::*;

	localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	logic [3:0]  current_port_q;
	logic        port_valid_q;
	logic [15:0] idle_ticks_q;
	logic [7:0]  running_status_q [NUM_PORTS];

	logic        accept;
	logic        port_in_range;
	logic        is_midi;
	logic        multi;
	logic        part_mode;
	logic        select;
	logic [3:0]  port_next;
	logic [7:0]  port_addr;
	logic [7:0]  rs_read;
	logic        is_channel_status;
	job_t        job;

	assign midi.ready = push_ready;
	assign accept = midi.valid && push_ready;
	assign port_in_range = {1'b0, midi.port} < 5'(NUM_PORTS);
	assign is_midi = (midi.opcode == OP_MIDI_BYTE) && port_in_range;
	assign multi = (cfg.adaptor_mode == MODE_MULTI_BURST);
	assign part_mode = (cfg.adaptor_mode == MODE_SOUND_MODULE) ||
		(cfg.adaptor_mode == MODE_GENERIC);
	assign select = midi.burst_start && part_mode && (!port_valid_q ||
		(current_port_q != midi.port) || (idle_ticks_q > cfg.idle_timeout));
	assign port_next = select ? midi.port : current_port_q;
	assign rs_read = running_status_q[midi.port[IDX_W-1:0]];
	assign is_channel_status = (midi.data_byte >= STATUS_LOW) &&
		(midi.data_byte < STATUS_SYSTEM);

	always_comb begin
		port_addr = {midi.port, ADDR_LOW_NIBBLE};
		if (port_addr == ADDR_PORT_ZERO) begin
			port_addr = ADDR_PORT_ZERO_SUB;
		end
	end

	always_comb begin
		job.bytes = '0;
		job.last_idx = 2'd0;
		if (multi) begin
			job.bytes[0] = port_addr;
			job.bytes[1] = midi.data_byte;
			job.last_idx = 2'd1;
		end else if (select) begin
			job.bytes[0] = BYTE_PORT_SELECT;
			job.bytes[1] = {4'd0, midi.port} + 8'd1;
			if (!midi.data_byte[7] && (cfg.adaptor_mode == MODE_SOUND_MODULE)) begin
				job.bytes[2] = rs_read;
				job.bytes[3] = midi.data_byte;
				job.last_idx = 2'd3;
			end else begin
				job.bytes[2] = midi.data_byte;
				job.last_idx = 2'd2;
			end
		end else begin
			job.bytes[0] = midi.data_byte;
		end
	end

	assign push_valid = midi.valid && is_midi;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_port_q <= '0;
			port_valid_q <= 1'b0;
			idle_ticks_q <= '0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				running_status_q[i] <= STATUS_LOW;
			end
		end else if (accept) begin
			if (midi.opcode == OP_IDLE_TICK) begin
				if (idle_ticks_q != 16'hFFFF) begin
					idle_ticks_q <= idle_ticks_q + 16'd1;
				end
			end else if (is_midi && !multi) begin
				current_port_q <= port_next;
				if (select) begin
					port_valid_q <= 1'b1;
				end
				// The store goes to the selected port, which may differ from the word's.
				if (is_channel_status && (port_valid_q || select)) begin
					running_status_q[port_next[IDX_W-1:0]] <= midi.data_byte;
				end
				idle_ticks_q <= '0;
			end
		end
	end

endmodule

// ----- hdl/mpsf_queue.sv -----
// ----------------------------------------------------------------------------
// Framer job queue
// Small first-in first-out store of byte jobs between front and back end.
// ----------------------------------------------------------------------------
module mpsf_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mpsf_pkg::job_t push_job,
	output logic           not_full,
	input  logic           pop,
	output mpsf_pkg::job_t pop_job,
	output logic           not_empty
);
	import mpsf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && not_full;
	assign do_pop = pop && not_empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/mpsf_back.sv -----
// ----------------------------------------------------------------------------
// Framer back end
// Takes jobs from the queue and sends their bytes one word at a time.
// ----------------------------------------------------------------------------
module mpsf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  mpsf_pkg::job_t job_in,
	output logic           job_pop,
	mpsf_out_if.source     serial
);
	import mpsf_pkg::*;

	job_t       job_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       fire;
	logic       at_last;

	assign at_last = (idx_q == job_q.last_idx);
	assign fire = busy_q && serial.ready;
	assign job_pop = job_valid && (!busy_q || (fire && at_last));

	assign serial.valid = busy_q;
	assign serial.tx_byte = job_q.bytes[idx_q];
	assign serial.last = at_last;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ----- hdl/midi_port_select_framer_unit.sv -----
// ----------------------------------------------------------------------------
// MIDI port-select framer
// Turns port-tagged MIDI bytes into one framed serial byte stream.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word contents
//  -------  ---------  ------------------------------------------------
//  midi     in         opcode, port, data_byte, burst_start
//  serial   out        tx_byte, last
//  cfg_*    in         register index and data, written when cfg_we is high
//
// A word on midi is taken whenever the job queue has room, so words may
// arrive back to back. Each MIDI byte word becomes a job of one to four
// bytes, and the back end sends one byte per cycle while serial is ready;
// a word therefore occupies the serial side for one byte slot per byte that
// it yields, and that single output byte slot sets the sustained rate. Idle
// ticks and words for ports beyond the configured count yield nothing.
// Reset clears the port-select state and sets every stored running status
// to 0x80; it takes effect at once, with no clearing pass. A stall on
// serial backs up through the queue to midi.ready only once the queue is
// full.
//
// The front end holds all port-select state and updates it as each word is
// accepted, so a following word always sees the effect of the one before.
// The queue then lets the two ends stall independently of each other.
//
module midi_port_select_framer_unit #(
	parameter int NUM_PORTS   = mpsf_pkg::NUM_PORTS_DEF,
	parameter int QUEUE_DEPTH = mpsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mpsf_in_if.sink     midi,
	mpsf_out_if.source  serial,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import mpsf_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	job_t push_job;
	logic not_full;
	logic pop;
	job_t pop_job;
	logic not_empty;

	// Configuration registers; the user must write them only while the framer is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adaptor_mode <= ADAPTOR_MODE_RST;
			cfg_q.idle_timeout <= IDLE_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADAPTOR_MODE: cfg_q.adaptor_mode <= cfg_data[2:0];
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: accepts words, applies the framing rules and builds jobs.
	mpsf_front #(
		.NUM_PORTS(NUM_PORTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.midi      (midi),
		.push_valid(push_valid),
		.push_job  (push_job),
		.push_ready(not_full)
	);

	// Queue of pending jobs between the two ends.
	mpsf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_job (push_job),
		.not_full (not_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.not_empty(not_empty)
	);

	// Back end: sends each job's bytes, flagging the final one.
	mpsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(not_empty),
		.job_in   (pop_job),
		.job_pop  (pop),
		.serial   (serial)
	);

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Port-select framer testbench
// Drives tagged MIDI words and idle ticks into the framer, predicts the
// framed serial bytes of every accepted word and checks them in order,
// under random idling on both channels and across several register settings.
// ----------------------------------------------------------------------------
module tb;
	import mpsf_pkg::*;

	// The block is built with its default port count.
	localparam int PORT_COUNT = NUM_PORTS_DEF;

	// Mode codes beyond the named ones; the block treats them as single port.
	localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

	// The smallest non-zero and the largest idle timeout, and the saturated tick count.
	localparam logic [15:0] TIMEOUT_MIN = 16'd1;
	localparam logic [15:0] TIMEOUT_MAX = 16'hFFFF;
	localparam logic [15:0] TICKS_SAT   = 16'hFFFF;

	// Timeout used to probe the boundary of the idle comparison.
	localparam int unsigned IDLE_EDGE_TICKS = 4;

	// A word yields at most four bytes on the serial side and the queue holds
	// two jobs, so SETTLE_CYCLES of quiet is ample for the block to go idle.
	localparam int SETTLE_CYCLES    = 12;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int RANDOM_PHASES    = 13;
	localparam int WORDS_PER_PHASE  = 16;
	localparam int MAX_PRINTED      = 40;

	// One framed byte as it is expected on the serial channel.
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} serial_byte_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;

	mpsf_in_if  midi_ch ();
	mpsf_out_if serial_ch ();

	midi_port_select_framer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.midi      (midi_ch),
		.serial    (serial_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our own copy of the framer's registers and port-select state.
	logic [2:0]  cfg_mode;
	logic [15:0] cfg_timeout;
	logic [3:0]  sel_port;
	logic        sel_valid;
	logic [7:0]  status_mem [PORT_COUNT];
	logic [15:0] idle_count;

	// Framed bytes that have been predicted but not yet seen, oldest first.
	serial_byte_t pending_bytes[$];

	// Knobs shared between the test tasks and the channel processes.
	bit gaps_on;
	bit stalls_on;
	bit long_hold_req;

	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned midi_words;
	int unsigned tick_words;
	int unsigned bytes_checked;
	int unsigned reg_writes;
	logic [3:0]  last_port;

	// The clock runs with a period of two units from time zero.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Should the design hang, the run is ended here once the count runs out.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d bytes outstanding",
			cycle_count, pending_bytes.size());
		$display("== FAIL ==");
		$finish;
	end

	// Each mismatch gets one line, up to a cap, and is always counted.
	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		end
	endtask

	// Works out the bytes that one accepted word frames into and updates the
	// port-select state exactly as the framer does. An idle tick only ages
	// the link. In multi-burst mode every byte carries an address byte in
	// front of it, and the idle count is left alone. In the part-select modes
	// the first byte of a burst is preceded by a port select when the port
	// changed, no port has been chosen yet, or the link has been idle for
	// longer than the timeout; sound-module mode also replays the port's
	// running status ahead of a data byte.
	function automatic void frame_word(input logic op, input logic [3:0] port,
		input logic [7:0] data, input logic burst);
		logic [7:0] frame[$];
		logic [7:0] addr;
		serial_byte_t entry;
		if (op == OP_IDLE_TICK) begin
			if (idle_count != TICKS_SAT) idle_count++;
			return;
		end
		if (int'(port) >= PORT_COUNT) return;
		if (cfg_mode == MODE_MULTI_BURST) begin
			addr = {port, ADDR_LOW_NIBBLE};
			// Port zero would give a data-looking address, so it is swapped.
			if (addr == ADDR_PORT_ZERO) addr = ADDR_PORT_ZERO_SUB;
			frame.push_back(addr);
			frame.push_back(data);
		end else begin
			if (burst && (cfg_mode == MODE_SOUND_MODULE || cfg_mode == MODE_GENERIC) &&
				(!sel_valid || sel_port != port || idle_count > cfg_timeout)) begin
				sel_port = port;
				sel_valid = 1'b1;
				frame.push_back(BYTE_PORT_SELECT);
				frame.push_back({4'h0, port} + 8'd1);
				if (data < STATUS_LOW && cfg_mode == MODE_SOUND_MODULE) begin
					frame.push_back(status_mem[port]);
				end
			end
			frame.push_back(data);
			// Channel status is remembered for the selected port, which need
			// not be the port that the word is tagged with.
			if (data >= STATUS_LOW && data < STATUS_SYSTEM && sel_valid) begin
				status_mem[sel_port] = data;
			end
			idle_count = '0;
		end
		foreach (frame[i]) begin
			entry.tx_byte = frame[i];
			entry.last = (i == frame.size() - 1);
			pending_bytes.push_back(entry);
		end
	endfunction

	// Offers one word on the midi channel and returns at the edge that takes
	// it. Valid is left high so that a following word can go out back to
	// back; a random gap lowers it first when gaps are enabled.
	task automatic send_word(input logic op, input logic [3:0] port,
		input logic [7:0] data, input logic burst);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			midi_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		midi_ch.valid       <= 1'b1;
		midi_ch.opcode      <= op;
		midi_ch.port        <= port;
		midi_ch.data_byte   <= data;
		midi_ch.burst_start <= burst;
		@(posedge clk);
		while (midi_ch.ready !== 1'b1) @(posedge clk);
		frame_word(op, port, data, burst);
		if (op == OP_MIDI_BYTE) midi_words++;
		else tick_words++;
	endtask

	// Idle ticks carry random junk in the fields that they do not use.
	task automatic send_ticks(input int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++) begin
			send_word(OP_IDLE_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		end
	endtask

	// Stops offering words and waits for every predicted byte, then lets the
	// block settle so that trailing idle ticks are surely absorbed.
	task automatic drain_and_settle;
		midi_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register; only ever called with the block idle.
	task automatic write_reg(input logic index, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_ADAPTOR_MODE) cfg_mode = value[2:0];
		else cfg_timeout = value;
		reg_writes++;
	endtask

	task automatic set_mode(input logic [2:0] mode);
		write_reg(REG_ADAPTOR_MODE, {13'd0, mode});
	endtask

	// The serial side: random stalls, plus one long hold on request, all
	// counted here so that the sender is free to keep offering words.
	initial begin : serial_sink
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left = 0;
		serial_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				serial_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left != 0) begin
				serial_ch.ready <= 1'b0;
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 11) == 0) begin
				serial_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				serial_ch.ready <= 1'b1;
			end
		end
	end

	// Every byte taken from the serial channel is held against the oldest
	// prediction, field by field.
	always @(posedge clk) begin : serial_check
		serial_byte_t want;
		if (arst_n && serial_ch.valid === 1'b1 && serial_ch.ready === 1'b1) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %b",
					serial_ch.tx_byte, serial_ch.last));
			end else begin
				want = pending_bytes.pop_front();
				bytes_checked++;
				if (serial_ch.tx_byte !== want.tx_byte) begin
					report_mismatch($sformatf("tx_byte %02h, expected %02h",
						serial_ch.tx_byte, want.tx_byte));
				end
				if (serial_ch.last !== want.last) begin
					report_mismatch($sformatf("last %b on byte %02h, expected %b",
						serial_ch.last, want.tx_byte, want.last));
				end
			end
		end
	end

	// Straight after reset: generic mode with the default timeout. A status
	// byte with no port chosen is passed on but not stored, the first burst
	// selects its port, a status byte on another port lands in the selected
	// port's slot, and a short idle spell does not force a fresh select.
	task automatic test_reset_and_part_select;
		send_word(OP_MIDI_BYTE, 4'd3, 8'h90, 1'b0);
		send_word(OP_MIDI_BYTE, 4'd3, 8'h45, 1'b1);
		send_word(OP_MIDI_BYTE, 4'd5, 8'h91, 1'b0);
		send_ticks(1);
		send_word(OP_MIDI_BYTE, 4'd3, 8'h7F, 1'b1);
		drain_and_settle();
	endtask

	// Sound-module mode with the shortest timeout: the reset running status
	// is replayed on the top port, a stored status comes back after the link
	// went idle, and system bytes are neither replayed against nor stored.
	task automatic test_sound_module_status;
		set_mode(MODE_SOUND_MODULE);
		write_reg(REG_IDLE_TIMEOUT, TIMEOUT_MIN);
		send_word(OP_MIDI_BYTE, 4'd15, 8'h12, 1'b1);
		send_word(OP_MIDI_BYTE, 4'd15, 8'hE5, 1'b0);
		send_ticks(2);
		send_word(OP_MIDI_BYTE, 4'd15, 8'h34, 1'b1);
		send_ticks(2);
		send_word(OP_MIDI_BYTE, 4'd15, 8'hF0, 1'b1);
		send_word(OP_MIDI_BYTE, 4'd15, 8'hEF, 1'b0);
		send_word(OP_MIDI_BYTE, 4'd0, 8'hFF, 1'b1);
		drain_and_settle();
	endtask

	// Multi-burst addressing, including the swapped address of port zero and
	// the top port whose address happens to be the same byte.
	task automatic test_multi_burst_addressing;
		set_mode(MODE_MULTI_BURST);
		send_word(OP_MIDI_BYTE, 4'd0, 8'h00, 1'b1);
		send_word(OP_MIDI_BYTE, 4'd15, 8'hFF, 1'b0);
		send_word(OP_MIDI_BYTE, 4'd7, 8'h80, 1'b1);
		drain_and_settle();
	endtask

	// Single-port, single-addressed and the spare mode codes pass every byte
	// straight through, burst start or not.
	task automatic test_pass_through_modes;
		set_mode(MODE_SINGLE_PORT);
		send_word(OP_MIDI_BYTE, 4'd9, 8'hC3, 1'b1);
		drain_and_settle();
		set_mode(MODE_SINGLE_ADDRESSED);
		send_word(OP_MIDI_BYTE, 4'd10, 8'h01, 1'b1);
		drain_and_settle();
		set_mode(MODE_SPARE_LO);
		send_word(OP_MIDI_BYTE, 4'd1, 8'hB0, 1'b1);
		drain_and_settle();
		set_mode(MODE_SPARE_MID);
		send_word(OP_MIDI_BYTE, 4'd2, 8'h7E, 1'b1);
		drain_and_settle();
		set_mode(MODE_SPARE_HI);
		send_word(OP_MIDI_BYTE, 4'd4, 8'hF7, 1'b1);
		drain_and_settle();
	endtask

	// The idle count is compared strictly against the timeout: a spell of
	// exactly the timeout keeps the chosen port, one tick more forces a
	// fresh port select on the port that is already chosen.
	task automatic test_idle_timeout_edge;
		set_mode(MODE_GENERIC);
		write_reg(REG_IDLE_TIMEOUT, 16'(IDLE_EDGE_TICKS));
		send_word(OP_MIDI_BYTE, 4'd2, 8'h22, 1'b1);
		send_ticks(IDLE_EDGE_TICKS);
		send_word(OP_MIDI_BYTE, 4'd2, 8'h23, 1'b1);
		send_ticks(IDLE_EDGE_TICKS + 1);
		send_word(OP_MIDI_BYTE, 4'd2, 8'h24, 1'b1);
		drain_and_settle();
	endtask

	// The serial side holds off for a long stretch while words keep coming,
	// so the queue fills and midi.ready drops; afterwards the sender waits
	// for every byte before going on.
	task automatic test_backpressure;
		int unsigned i;
		write_reg(REG_IDLE_TIMEOUT, 16'd3000);
		set_mode(MODE_SOUND_MODULE);
		gaps_on = 1'b0;
		long_hold_req = 1'b1;
		for (i = 0; i < 24; i++) begin
			send_word(OP_MIDI_BYTE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 8'h7F)),
				1'b1);
		end
		gaps_on = 1'b1;
		drain_and_settle();
	endtask

	// One well-formed burst: sometimes an idle spell first, around the timeout
	// when that is small, then a run of bytes on one port led by a burst start
	// on a channel status byte or a data byte, mostly followed by data.
	task automatic send_burst;
		int unsigned len;
		int unsigned i;
		logic [3:0] port;
		logic [7:0] data;
		if ($urandom_range(0, 1) == 0) begin
			if (cfg_timeout <= 16'd16) send_ticks($urandom_range(0, int'(cfg_timeout) + 2));
			else send_ticks($urandom_range(0, 3));
		end
		port = ($urandom_range(0, 4) < 2) ? last_port : 4'($urandom_range(0, 15));
		last_port = port;
		len = $urandom_range(1, 5);
		for (i = 0; i < len; i++) begin
			if (i == 0 && $urandom_range(0, 1) == 0) data = 8'($urandom_range(8'h80, 8'hEF));
			else if (i != 0 && $urandom_range(0, 9) == 0) data = 8'($urandom_range(8'h80, 8'hFF));
			else data = 8'($urandom_range(0, 8'h7F));
			send_word(OP_MIDI_BYTE, port, data, i == 0);
		end
	endtask

	// Random traffic over a series of settings. Most of it is well-formed
	// bursts; the rest is words with every field random. The final phase
	// runs with no idling on either side.
	task automatic test_random_traffic;
		logic [2:0] mode_plan [RANDOM_PHASES];
		int unsigned phase;
		int unsigned target;
		logic [15:0] timeout;
		mode_plan = '{MODE_SOUND_MODULE, MODE_GENERIC, MODE_MULTI_BURST, MODE_SOUND_MODULE,
			MODE_SINGLE_PORT, MODE_GENERIC, MODE_SINGLE_ADDRESSED, MODE_SPARE_LO,
			MODE_SOUND_MODULE, MODE_SPARE_MID, MODE_GENERIC, MODE_SPARE_HI,
			MODE_SOUND_MODULE};
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) timeout = TIMEOUT_MIN;
			else if (phase == 1) timeout = TIMEOUT_MAX;
			else if ($urandom_range(0, 5) == 0) timeout = TIMEOUT_MAX;
			else timeout = 16'($urandom_range(1, 12));
			set_mode(mode_plan[phase]);
			write_reg(REG_IDLE_TIMEOUT, timeout);
			if (phase == RANDOM_PHASES - 1) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			target = midi_words + WORDS_PER_PHASE;
			while (midi_words < target) begin
				if ($urandom_range(0, 9) < 7) begin
					send_burst();
				end else begin
					send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end
			end
			drain_and_settle();
		end
	endtask

	// Reset is held with every input at a known value; the tests then run in
	// turn and the verdict follows.
	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_ADAPTOR_MODE;
		cfg_data            <= '0;
		midi_ch.valid       <= 1'b0;
		midi_ch.opcode      <= OP_MIDI_BYTE;
		midi_ch.port        <= '0;
		midi_ch.data_byte   <= '0;
		midi_ch.burst_start <= 1'b0;
		cycle_count   = 0;
		mismatches    = 0;
		midi_words    = 0;
		tick_words    = 0;
		bytes_checked = 0;
		reg_writes    = 0;
		last_port     = '0;
		gaps_on       = 1'b1;
		stalls_on     = 1'b1;
		long_hold_req = 1'b0;
		cfg_mode      = ADAPTOR_MODE_RST;
		cfg_timeout   = IDLE_TIMEOUT_RST;
		sel_port      = '0;
		sel_valid     = 1'b0;
		idle_count    = '0;
		foreach (status_mem[i]) status_mem[i] = STATUS_LOW;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_part_select();
		test_sound_module_status();
		test_multi_burst_addressing();
		test_pass_through_modes();
		test_idle_timeout_edge();
		test_backpressure();
		test_random_traffic();

		$display("Sent %0d MIDI words and %0d idle ticks through %0d register writes,",
			midi_words, tick_words, reg_writes);
		$display("covering all adaptor modes, both timeout extremes and a long serial stall.");
		$display("Checked %0d framed bytes, %0d mismatches.", bytes_checked, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
